// ----- design/ldpcnms_pkg.sv -----
// Shared types, constants and register codes for the layered NMS check-node unit.
// Used by ldpcnms_alu and ldpc_layered_nms_check_node_unit; no dependencies.
package ldpcnms_pkg;

    // Default maximum check-node degree (edge store depth)
    localparam int MAX_DEGREE_DEF = 32;

    // Fixed field widths
    localparam int LLR_W = 8;
    localparam int MAG_W = 7;
    localparam int NORM_W = 8;
    localparam int IDX_W = 5;
    localparam int NORM_SHIFT = 5;

    // Magnitude ceiling and run reset values
    localparam logic [MAG_W-1:0] MAG_MAX = 7'd127;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VAR_FLOOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MSG_LIMIT = 2'd2;
    localparam logic [NORM_W-1:0] NORM_FACTOR_RST = 8'd24;
    localparam logic signed [LLR_W-1:0] VAR_FLOOR_RST = -8'sd127;
    localparam logic [MAG_W-1:0] MSG_LIMIT_RST = 7'd127;

    // Shared unit operation codes
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_ABSORB = 2'd0;
    localparam logic [OP_W-1:0] OP_SCALE = 2'd1;
    localparam logic [OP_W-1:0] OP_EMIT = 2'd2;

    // Run context handed to the shared unit
    typedef struct packed {
        logic [NORM_W-1:0] norm_factor;
        logic signed [LLR_W-1:0] var_floor;
        logic [MAG_W-1:0] msg_limit;
        logic [MAG_W-1:0] least_mag;
        logic [MAG_W-1:0] scaled_hi;
        logic [MAG_W-1:0] scaled_lo;
        logic neg_base;
    } alu_ctx_t;

endpackage

// ----- design/ldpcnms_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ldpcnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/ldpcnms_alu.sv -----
// Shared arithmetic unit: extrinsic subtract, normalization multiply, message update.
// Depends on ldpcnms_pkg.
module ldpcnms_alu (
    input  logic [ldpcnms_pkg::OP_W-1:0]         op,
    input  logic signed [ldpcnms_pkg::LLR_W-1:0] opa,
    input  logic signed [ldpcnms_pkg::LLR_W-1:0] opb,
    input  logic [ldpcnms_pkg::MAG_W-1:0]        scale_in,
    input  ldpcnms_pkg::alu_ctx_t                ctx,
    output logic signed [ldpcnms_pkg::LLR_W-1:0] res_val,
    output logic signed [ldpcnms_pkg::LLR_W-1:0] res_msg,
    output logic [ldpcnms_pkg::MAG_W-1:0]        res_mag
);

    localparam int SUM_W = ldpcnms_pkg::LLR_W + 2;
    localparam int PROD_W = ldpcnms_pkg::MAG_W + ldpcnms_pkg::NORM_W;
    localparam int SH_W = PROD_W - ldpcnms_pkg::NORM_SHIFT;

    // |v| saturated to 127, then clipped to the limit
    function automatic logic [ldpcnms_pkg::MAG_W-1:0] mag_of(
        input logic signed [ldpcnms_pkg::LLR_W-1:0] v,
        input logic [ldpcnms_pkg::MAG_W-1:0]        limit
    );
        logic [ldpcnms_pkg::LLR_W-1:0] a;
        logic [ldpcnms_pkg::MAG_W-1:0] m;
        a = v[ldpcnms_pkg::LLR_W-1] ? ldpcnms_pkg::LLR_W'(-v) : ldpcnms_pkg::LLR_W'(v);
        m = a[ldpcnms_pkg::LLR_W-1] ? ldpcnms_pkg::MAG_MAX : a[ldpcnms_pkg::MAG_W-1:0];
        return (m > limit) ? limit : m;
    endfunction

    logic [ldpcnms_pkg::MAG_W-1:0]        mag_a;
    logic [ldpcnms_pkg::MAG_W-1:0]        mag_sel;
    logic                                 neg;
    logic signed [ldpcnms_pkg::LLR_W-1:0] nm;
    logic signed [SUM_W-1:0]              addend;
    logic signed [SUM_W-1:0]              sum;
    logic signed [ldpcnms_pkg::LLR_W-1:0] sat;
    logic signed [ldpcnms_pkg::LLR_W-1:0] val;
    logic [PROD_W-1:0]                    prod;
    logic [SH_W-1:0]                      prod_sh;
    logic [ldpcnms_pkg::MAG_W-1:0]        scaled;

    // Message for a stored edge: pick the other minimum, apply the sign
    always_comb
    begin
        mag_a = mag_of(opa, ctx.msg_limit);
        mag_sel = (mag_a == ctx.least_mag) ? ctx.scaled_hi : ctx.scaled_lo;
        neg = ctx.neg_base ^ opa[ldpcnms_pkg::LLR_W-1];
        nm = neg ? -$signed({1'b0, mag_sel}) : $signed({1'b0, mag_sel});
    end

    // Saturating add or subtract, clamped at the floor
    always_comb
    begin
        if (op == ldpcnms_pkg::OP_EMIT)
        begin
            addend = SUM_W'(nm);
        end
        else
        begin
            addend = -SUM_W'(opb);
        end
        sum = SUM_W'(opa) + addend;
        if (sum > SUM_W'(127))
        begin
            sat = 8'sd127;
        end
        else if (sum < -SUM_W'(128))
        begin
            sat = -8'sd128;
        end
        else
        begin
            sat = sum[ldpcnms_pkg::LLR_W-1:0];
        end
        val = (sat < ctx.var_floor) ? ctx.var_floor : sat;
    end

    // Normalization multiply, shift and saturate
    always_comb
    begin
        prod = PROD_W'(scale_in) * PROD_W'(ctx.norm_factor);
        prod_sh = prod[PROD_W-1:ldpcnms_pkg::NORM_SHIFT];
        scaled = (prod_sh > SH_W'(ldpcnms_pkg::MAG_MAX)) ? ldpcnms_pkg::MAG_MAX
                                                          : prod_sh[ldpcnms_pkg::MAG_W-1:0];
    end

    assign res_val = val;
    assign res_msg = nm;
    assign res_mag = (op == ldpcnms_pkg::OP_SCALE) ? scaled : mag_of(val, ctx.msg_limit);

endmodule

// ----- design/ldpc_layered_nms_check_node_unit.sv -----
// Top level of the layered normalized min-sum check-node unit: sequencer and run state.
// Depends on ldpcnms_pkg, ldpcnms_ram and ldpcnms_alu.

// Each edge beat on the input stream is absorbed as it is accepted: its extrinsic
// value goes to the edge store RAM and the sign parity and two smallest magnitudes
// are updated. The beat flagged with tlast closes the check node; the shared
// arithmetic unit then computes the two normalization products in turn and the
// block emits one result per stored edge, one per cycle while the output side
// takes them, in arrival order. s_tready is low from after the tlast beat until
// the final result is loaded into the output register. Edges beyond MAX_DEGREE
// are dropped and every result of that run carries the overflow flag in m_tuser.
// The store needs no clearing after reset. Configuration is taken on any cycle
// and must only change while the block is idle.
module ldpc_layered_nms_check_node_unit #(
    parameter int MAX_DEGREE = ldpcnms_pkg::MAX_DEGREE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Edge input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] var_llr, [15:8] old_msg
    input  logic        s_tlast,   // last_edge
    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] new_msg, [15:8] new_var_llr, [20:16] edge_index
    output logic        m_tlast,   // last_result
    output logic        m_tuser,   // degree_overflow
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int ADDR_W = $clog2(MAX_DEGREE);
    localparam int CNT_W = $clog2(MAX_DEGREE + 1);
    localparam int LLR_W = ldpcnms_pkg::LLR_W;
    localparam int MAG_W = ldpcnms_pkg::MAG_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCALE_HI = 2'd1;
    localparam logic [1:0] ST_SCALE_LO = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [ADDR_W-1:0]           idx_reg, idx_next;
    logic [MAG_W-1:0]            least_reg, least_next;
    logic [MAG_W-1:0]            second_reg, second_next;
    logic                        parity_reg, parity_next;
    logic                        ovf_reg, ovf_next;
    logic [MAG_W-1:0]            c_hi_reg, c_hi_next;
    logic [MAG_W-1:0]            c_lo_reg, c_lo_next;

    logic [ldpcnms_pkg::NORM_W-1:0] norm_reg;
    logic signed [LLR_W-1:0]        floor_reg;
    logic [MAG_W-1:0]               limit_reg;

    logic                        m_valid_reg, m_valid_next;
    logic signed [LLR_W-1:0]     m_msg_reg, m_msg_next;
    logic signed [LLR_W-1:0]     m_var_reg, m_var_next;
    logic [ldpcnms_pkg::IDX_W-1:0] m_idx_reg, m_idx_next;
    logic                        m_last_reg, m_last_next;
    logic                        m_ovf_reg, m_ovf_next;

    logic                        s_fire;
    logic                        has_room;
    logic                        out_load;
    logic                        is_last;
    logic                        wr_en;
    logic                        rd_en;
    logic [ADDR_W-1:0]           rd_addr;
    logic [LLR_W-1:0]            rd_data;

    logic [ldpcnms_pkg::OP_W-1:0] alu_op;
    logic [MAG_W-1:0]             alu_scale_in;
    ldpcnms_pkg::alu_ctx_t        alu_ctx;
    logic signed [LLR_W-1:0]      alu_val;
    logic signed [LLR_W-1:0]      alu_msg;
    logic [MAG_W-1:0]             alu_mag;
    logic [MAG_W-1:0]             hi_mag;

    // Handshake terms
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire = s_tvalid && s_tready;
    assign has_room = (count_reg < CNT_W'(MAX_DEGREE));
    assign out_load = !m_valid_reg || m_tready;
    assign is_last = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));
    assign cfg_ready = 1'b1;

    // Edge store
    assign wr_en = s_fire && has_room;
    assign rd_en = (state_reg == ST_SCALE_LO) ||
                   ((state_reg == ST_EMIT) && out_load && !is_last);
    assign rd_addr = (state_reg == ST_SCALE_LO) ? '0 : (idx_reg + ADDR_W'(1));

    ldpcnms_ram #(
        .WIDTH (LLR_W),
        .DEPTH (MAX_DEGREE)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (alu_val),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared unit operand selection
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:     alu_op = ldpcnms_pkg::OP_ABSORB;
            ST_SCALE_HI: alu_op = ldpcnms_pkg::OP_SCALE;
            ST_SCALE_LO: alu_op = ldpcnms_pkg::OP_SCALE;
            ST_EMIT:     alu_op = ldpcnms_pkg::OP_EMIT;
            default:     alu_op = ldpcnms_pkg::OP_ABSORB;
        endcase
        alu_scale_in = (state_reg == ST_SCALE_HI) ? second_reg : least_reg;
        alu_ctx.norm_factor = norm_reg;
        alu_ctx.var_floor = floor_reg;
        alu_ctx.msg_limit = limit_reg;
        alu_ctx.least_mag = least_reg;
        alu_ctx.scaled_hi = c_hi_reg;
        alu_ctx.scaled_lo = c_lo_reg;
        alu_ctx.neg_base = parity_reg ^ count_reg[0];
    end

    ldpcnms_alu u_alu (
        .op       (alu_op),
        .opa      ((state_reg == ST_EMIT) ? $signed(rd_data) : $signed(s_tdata[7:0])),
        .opb      ($signed(s_tdata[15:8])),
        .scale_in (alu_scale_in),
        .ctx      (alu_ctx),
        .res_val  (alu_val),
        .res_msg  (alu_msg),
        .res_mag  (alu_mag)
    );

    assign hi_mag = (alu_mag > least_reg) ? alu_mag : least_reg;

    // Sequencer and run state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        least_next = least_reg;
        second_next = second_reg;
        parity_next = parity_reg;
        ovf_next = ovf_reg;
        c_hi_next = c_hi_reg;
        c_lo_next = c_lo_reg;
        m_valid_next = m_valid_reg;
        m_msg_next = m_msg_reg;
        m_var_next = m_var_reg;
        m_idx_next = m_idx_reg;
        m_last_next = m_last_reg;
        m_ovf_next = m_ovf_reg;

        // output beat taken
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        parity_next = parity_reg ^ alu_val[LLR_W-1];
                        if (alu_mag < least_reg)
                        begin
                            least_next = alu_mag;
                        end
                        if (hi_mag < second_reg)
                        begin
                            second_next = hi_mag;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_SCALE_HI;
                    end
                end
            end
            ST_SCALE_HI:
            begin
                c_hi_next = alu_mag;
                state_next = ST_SCALE_LO;
            end
            ST_SCALE_LO:
            begin
                c_lo_next = alu_mag;
                idx_next = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    m_msg_next = alu_msg;
                    m_var_next = alu_val;
                    m_idx_next = ldpcnms_pkg::IDX_W'(idx_reg);
                    m_last_next = is_last;
                    m_ovf_next = ovf_reg;
                    if (is_last)
                    begin
                        count_next = '0;
                        least_next = ldpcnms_pkg::MAG_MAX;
                        second_next = ldpcnms_pkg::MAG_MAX;
                        parity_next = 1'b0;
                        ovf_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            least_reg <= ldpcnms_pkg::MAG_MAX;
            second_reg <= ldpcnms_pkg::MAG_MAX;
            parity_reg <= 1'b0;
            ovf_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            least_reg <= least_next;
            second_reg <= second_next;
            parity_reg <= parity_next;
            ovf_reg <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        c_hi_reg <= c_hi_next;
        c_lo_reg <= c_lo_next;
        m_msg_reg <= m_msg_next;
        m_var_reg <= m_var_next;
        m_idx_reg <= m_idx_next;
        m_last_reg <= m_last_next;
        m_ovf_reg <= m_ovf_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_reg <= ldpcnms_pkg::NORM_FACTOR_RST;
            floor_reg <= ldpcnms_pkg::VAR_FLOOR_RST;
            limit_reg <= ldpcnms_pkg::MSG_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == ldpcnms_pkg::CFG_NORM_FACTOR)
            begin
                norm_reg <= cfg_data;
            end
            if (cfg_index == ldpcnms_pkg::CFG_VAR_FLOOR)
            begin
                floor_reg <= $signed(cfg_data);
            end
            if (cfg_index == ldpcnms_pkg::CFG_MSG_LIMIT)
            begin
                limit_reg <= cfg_data[MAG_W-1:0];
            end
        end
    end

    // Output port
    assign m_tvalid = m_valid_reg;
    assign m_tdata = {3'b000, m_idx_reg, m_var_reg, m_msg_reg};
    assign m_tlast = m_last_reg;
    assign m_tuser = m_ovf_reg;

endmodule
